// File: rtl/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg: shared definitions for the complex decimating FIR core
// Field widths, configuration register indexes, sequencer states and the
// fixed-point constants used by the multiply-accumulate unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdf_pkg;

  // Default depth of the delay line and coefficient memory.
  localparam int MAX_TAPS_DEF = 256;

  // Word field widths.
  localparam int SMP_W      = 16;
  localparam int COEF_W     = 18;
  localparam int DECIM_W    = 8;
  localparam int TAPS_W     = 9;
  localparam int TIDX_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;

  // Q1.15 times Q1.17 gives a Q2.32 product in 34 bits.
  localparam int PROD_W    = SMP_W + COEF_W;
  localparam int RND_SHIFT = 17;
  localparam int RND_HALF  = 65536;
  localparam int SAT_MAX   = 32767;
  localparam int SAT_MIN   = -32768;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TAP    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 8'd1;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    smp_t i;
    smp_t q;
  } smp_pair_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic vld;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } cdf_state_t;

endpackage

`default_nettype wire

// File: rtl/cdf_in_if.sv
// ----------------------------------------------------------------------------
// cdf_in_if: input word channel
// Carries samples and coefficient writes with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdf_in_if import cdf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  smp_t                sample_i;
  smp_t                sample_q;
  logic [TIDX_W-1:0]   tap_index;
  coef_t               tap_value;

  modport source (output valid, kind, sample_i, sample_q, tap_index, tap_value,
                  input ready);
  modport sink   (input valid, kind, sample_i, sample_q, tap_index, tap_value,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/cdf_out_if.sv
// ----------------------------------------------------------------------------
// cdf_out_if: result word channel
// Carries filtered or passed I/Q samples and the saturation flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdf_out_if import cdf_pkg::*; ();
  logic valid;
  logic ready;
  smp_t out_i;
  smp_t out_q;
  logic clipped;

  modport source (output valid, out_i, out_q, clipped, input ready);
  modport sink   (input valid, out_i, out_q, clipped, output ready);
endinterface

`default_nettype wire

// File: rtl/cdf_cfg_if.sv
// ----------------------------------------------------------------------------
// cdf_cfg_if: configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdf_cfg_if import cdf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/complex_decimating_fir_core.sv
// ----------------------------------------------------------------------------
// complex_decimating_fir_core: decimating FIR filter for complex samples
// Circular delay line and coefficient memory, a small sequencer and one
// shared multiply-accumulate unit that walks the taps one per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries words of two kinds. A coefficient word writes one tap
//   and leaves the core ready. A sample word enters the delay line; when the
//   decimation phase is zero and the line holds at least tap_count samples,
//   the filter output is computed and offered on out_ch.
//   cfg_ch writes decim_factor (index 0) and tap_count (index 1) and is always
//   ready; the user must write it only while the core is idle, which the core
//   does not enforce. With decim_factor of 0 or 1, or tap_count of 0, samples
//   pass straight through with clipped low; the delay line is left as it was.
// Timing:
//   A sample that produces no output leaves in_ready high. A pass-through
//   sample returns in_ready once the output register is free. A filtered
//   output walks the n taps in use: the single multiply-accumulate unit and
//   the one read port of each memory handle one tap per cycle.
//   The result sits in an output register, so the next word is taken while
//   it waits; a stalled receiver only blocks once a second result is ready.
// Reset:
//   Synchronous, active low. Configuration returns to pass-through, the fill
//   level and phase clear; the memories keep their contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module complex_decimating_fir_core import cdf_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cdf_in_if.sink    in_ch,
  cdf_out_if.source out_ch,
  cdf_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int NW = $clog2(MAX_TAPS + 1);

  cdf_state_t           state_r;
  cdf_state_t           state_nxt;
  logic [DECIM_W-1:0]   decim_r;
  logic [TAPS_W-1:0]    taps_r;
  logic [AW-1:0]        wp_r;
  logic [AW-1:0]        wp_nxt;
  logic [NW-1:0]        fill_r;
  logic [NW-1:0]        fill_nxt;
  logic [DECIM_W-1:0]   phase_r;
  logic [DECIM_W-1:0]   phase_nxt;
  logic [AW-1:0]        rd_addr_r;
  logic [AW-1:0]        rd_addr_nxt;
  logic [AW-1:0]        k_r;
  logic [AW-1:0]        k_nxt;
  logic                 rd_vld_r;
  smp_pair_t            hist_rd_r;
  coef_t                coef_rd_r;
  smp_t                 res_i_r;
  smp_t                 res_q_r;
  logic                 res_clip_r;
  logic                 out_vld_r;
  smp_t                 out_i_r;
  smp_t                 out_q_r;
  logic                 out_clip_r;

  smp_pair_t            hist_mem [MAX_TAPS];
  coef_t                coef_mem [MAX_TAPS];

  logic [NW-1:0]        n_eff;
  logic [NW-1:0]        nm1;
  logic                 passthru;
  logic                 in_acc;
  logic                 smp_acc;
  logic                 tap_acc;
  logic                 filt_acc;
  logic                 start_emit;
  logic                 last_issue;
  logic                 out_free;
  logic                 out_load;
  logic                 issue;
  logic [AW-1:0]        start_addr;
  mac_ctrl_t            mac_ctrl;
  logic                 mac_busy;
  smp_t                 mac_i;
  smp_t                 mac_q;
  logic                 mac_clip;

  // Taps in use, limited to the memory depth.
  always_comb begin
    if (int'(taps_r) > MAX_TAPS) begin
      n_eff = NW'(MAX_TAPS);
    end else begin
      n_eff = NW'(taps_r);
    end
    nm1 = n_eff - 1'b1;
  end

  // Handshake decode.
  assign passthru   = (decim_r <= DECIM_W'(1)) || (taps_r == '0);
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign smp_acc    = in_acc && (in_ch.kind == KIND_SAMPLE);
  assign tap_acc    = in_acc && (in_ch.kind == KIND_TAP);
  assign filt_acc   = smp_acc && !passthru;
  assign out_free   = !out_vld_r || out_ch.ready;
  assign last_issue = (state_r == ST_MAC) && (k_r == AW'(nm1));

  // Delay line pointer, fill level and decimation phase.
  always_comb begin
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    phase_nxt = phase_r;
    if (filt_acc) begin
      wp_nxt = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + 1'b1;
      if (int'(fill_r) < MAX_TAPS) begin
        fill_nxt = fill_r + 1'b1;
      end
      if (({1'b0, phase_r} + 1'b1) >= {1'b0, decim_r}) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  assign start_emit = filt_acc && (phase_r == '0) && (fill_nxt >= n_eff);

  // Oldest sample in the window sits n - 1 places behind the newest one.
  always_comb begin
    if (int'(wp_nxt) >= int'(nm1)) begin
      start_addr = AW'(int'(wp_nxt) - int'(nm1));
    end else begin
      start_addr = AW'(int'(wp_nxt) + MAX_TAPS - int'(nm1));
    end
  end

  // Tap walk: history address and coefficient index advance together.
  always_comb begin
    rd_addr_nxt = rd_addr_r;
    k_nxt       = k_r;
    if (start_emit) begin
      rd_addr_nxt = start_addr;
      k_nxt       = '0;
    end else if (issue) begin
      rd_addr_nxt = (rd_addr_r == AW'(MAX_TAPS - 1)) ? '0 : rd_addr_r + 1'b1;
      k_nxt       = k_r + 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_acc && passthru) begin
          state_nxt = ST_EMIT;
        end else if (start_emit) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready    = 1'b0;
    issue          = 1'b0;
    out_load       = 1'b0;
    mac_ctrl.clear = start_emit;
    mac_ctrl.vld   = rd_vld_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_MAC: begin
        issue = 1'b1;
      end
      ST_DRAIN: begin
        issue = 1'b0;
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      decim_r   <= DECIM_W'(1);
      taps_r    <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
      phase_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      phase_r  <= phase_nxt;
      rd_vld_r <= issue;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_DECIM: decim_r <= cfg_ch.data[DECIM_W-1:0];
          CFG_TAPS:  taps_r  <= cfg_ch.data[TAPS_W-1:0];
          default:   decim_r <= decim_r;
        endcase
      end
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Walk counters.
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    k_r       <= k_nxt;
  end

  // Delay line memory: write the newest sample, read one tap per cycle.
  always_ff @(posedge clk) begin
    if (filt_acc) begin
      hist_mem[wp_nxt] <= '{i: in_ch.sample_i, q: in_ch.sample_q};
    end
    hist_rd_r <= hist_mem[rd_addr_r];
  end

  // Coefficient memory; indexes beyond the depth are dropped.
  always_ff @(posedge clk) begin
    if (tap_acc && (int'(in_ch.tap_index) < MAX_TAPS)) begin
      coef_mem[AW'(in_ch.tap_index)] <= in_ch.tap_value;
    end
    coef_rd_r <= coef_mem[k_r];
  end

  cdf_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .smp   (hist_rd_r),
    .coef  (coef_rd_r),
    .busy  (mac_busy),
    .res_i (mac_i),
    .res_q (mac_q),
    .clip  (mac_clip)
  );

  // Result holding register, filled by pass-through or by the finished sum.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && smp_acc && passthru) begin
      res_i_r    <= in_ch.sample_i;
      res_q_r    <= in_ch.sample_q;
      res_clip_r <= 1'b0;
    end else if ((state_r == ST_DRAIN) && !mac_busy) begin
      res_i_r    <= mac_i;
      res_q_r    <= mac_q;
      res_clip_r <= mac_clip;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i_r    <= res_i_r;
      out_q_r    <= res_q_r;
      out_clip_r <= res_clip_r;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.out_i   = out_i_r;
  assign out_ch.out_q   = out_q_r;
  assign out_ch.clipped = out_clip_r;

endmodule

`default_nettype wire

// File: rtl/cdf_mac.sv
// ----------------------------------------------------------------------------
// cdf_mac: shared complex multiply-accumulate unit
// One registered multiply per lane, a wide accumulator, and round-and-
// saturate logic that turns the wide sum of Q2.32 products into a Q1.15 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdf_mac import cdf_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mac_ctrl_t ctrl,
  input  wire smp_pair_t smp,
  input  wire coef_t     coef,
  output logic           busy,
  output smp_t           res_i,
  output smp_t           res_q,
  output logic           clip
);

  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int QW    = ACC_W - RND_SHIFT;

  logic                     mul_vld_r;
  logic signed [PROD_W-1:0] prod_i_r;
  logic signed [PROD_W-1:0] prod_q_r;
  logic signed [ACC_W-1:0]  acc_i_r;
  logic signed [ACC_W-1:0]  acc_q_r;
  logic signed [ACC_W-1:0]  rnd_i;
  logic signed [ACC_W-1:0]  rnd_q;
  logic signed [QW-1:0]     quo_i;
  logic signed [QW-1:0]     quo_q;
  logic                     clip_i;
  logic                     clip_q;

  // Product stage; the valid tag follows the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_i_r <= smp.i * coef;
    prod_q_r <= smp.q * coef;
  end

  // Accumulate stage, cleared at the start of each output.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (mul_vld_r) begin
      acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
      acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
    end
  end

  assign busy = ctrl.vld | mul_vld_r;

  // Round half up, then drop the low RND_SHIFT fraction bits with an arithmetic shift.
  always_comb begin
    rnd_i = acc_i_r + ACC_W'(RND_HALF);
    rnd_q = acc_q_r + ACC_W'(RND_HALF);
    quo_i = rnd_i[ACC_W-1:RND_SHIFT];
    quo_q = rnd_q[ACC_W-1:RND_SHIFT];
  end

  // Saturate each lane to the Q1.15 range.
  always_comb begin
    clip_i = 1'b1;
    clip_q = 1'b1;
    if (quo_i > QW'(SAT_MAX)) begin
      res_i = smp_t'(SAT_MAX);
    end else if (quo_i < QW'(SAT_MIN)) begin
      res_i = smp_t'(SAT_MIN);
    end else begin
      res_i  = quo_i[SMP_W-1:0];
      clip_i = 1'b0;
    end
    if (quo_q > QW'(SAT_MAX)) begin
      res_q = smp_t'(SAT_MAX);
    end else if (quo_q < QW'(SAT_MIN)) begin
      res_q = smp_t'(SAT_MIN);
    end else begin
      res_q  = quo_q[SMP_W-1:0];
      clip_q = 1'b0;
    end
    clip = clip_i | clip_q;
  end

endmodule

`default_nettype wire

// File: rtl/cdf_checker.sv
// ----------------------------------------------------------------------------
// cdf_checker: port-level checks for the complex decimating FIR core
// Watches the input and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdf_checker import cdf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_kind,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire smp_t out_i,
  input wire smp_t out_q,
  input wire logic clipped
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_i) && $stable(out_q) && $stable(clipped))
    else $error("result payload changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

  // A saturated result sits at one of the range limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |->
      (out_i == smp_t'(SAT_MAX)) || (out_i == smp_t'(SAT_MIN)) ||
      (out_q == smp_t'(SAT_MAX)) || (out_q == smp_t'(SAT_MIN)))
    else $error("clipped set on an unsaturated result");

  // A coefficient word is absorbed at once, so the core stays ready.
  a_tap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_TAP) |=> in_ready)
    else $error("core not ready after a coefficient word");

endmodule

bind complex_decimating_fir_core cdf_checker u_cdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_i     (out_ch.out_i),
  .out_q     (out_ch.out_q),
  .clipped   (out_ch.clipped)
);

`default_nettype wire
